/* hw/rtl/cgpd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cgpd_pkg
// Shared types, constants and tables for the CPR global pair decoder.
// ----------------------------------------------------------------------------
package cgpd_pkg;

	localparam int unsigned ID_W    = 24;
	localparam int unsigned CPR_W   = 17;
	localparam int unsigned TIME_W  = 32;
	localparam int unsigned WIN_W   = 16;
	localparam int unsigned ANG_W   = 32;
	localparam int unsigned ZONE_W  = 6;
	localparam int unsigned LAT_W   = 34;

	localparam logic [WIN_W-1:0] WINDOW_RESET = 16'd10000;

	localparam logic [ZONE_W-1:0] ZONES_EVEN = 6'd60;
	localparam logic [ZONE_W-1:0] ZONES_ODD  = 6'd59;
	localparam logic [ZONE_W-1:0] NL_MAX     = 6'd59;

	// Divider geometry: numerator, divisor, remainder, two quotient bits per cycle
	localparam int unsigned NUM_W     = 40;
	localparam int unsigned DEN_W     = 7;
	localparam int unsigned REM_W     = 8;
	localparam int unsigned DIV_STEPS = NUM_W / 2;

	// Latitude zone thresholds in units of 1e-8 degree
	localparam int unsigned NL_THR_N = 58;
	typedef logic [63:0] thr_arr_t [NL_THR_N];
	localparam thr_arr_t NL_THR = '{
		64'd1047047130, 64'd1482817437, 64'd1818626357, 64'd2102939493, 64'd2354504487,
		64'd2582924707, 64'd2793898710, 64'd2991135686, 64'd3177209708, 64'd3353993436,
		64'd3522899598, 64'd3685025108, 64'd3841241892, 64'd3992256684, 64'd4138651832,
		64'd4280914012, 64'd4419454951, 64'd4554626723, 64'd4686733252, 64'd4816039128,
		64'd4942776439, 64'd5067150166, 64'd5189342469, 64'd5309516153, 64'd5427817472,
		64'd5544378444, 64'd5659318756, 64'd5772747354, 64'd5884763776, 64'd5995459277,
		64'd6104917774, 64'd6213216659, 64'd6320427479, 64'd6426616523, 64'd6531845310,
		64'd6636171008, 64'd6739646774, 64'd6842322022, 64'd6944242631, 64'd7045451075,
		64'd7145986473, 64'd7245884545, 64'd7345177442, 64'd7443893416, 64'd7542056257,
		64'd7639684391, 64'd7736789461, 64'd7833374083, 64'd7929428225, 64'd8024923213,
		64'd8119801349, 64'd8213956981, 64'd8307199445, 64'd8399173563, 64'd8489166191,
		64'd8575541621, 64'd8653536998, 64'd8700000000
	};

	// Thresholds as binary angles: smallest |a| with |a|*45e8 >= thr*2^29
	typedef logic [ANG_W-1:0] lim_arr_t [NL_THR_N];

	function automatic lim_arr_t make_lims();
		lim_arr_t    l;
		logic [63:0] p;
		for (int i = 0; i < NL_THR_N; i++) begin
			p    = (NL_THR[i] << 29) + 64'd4499999999;
			l[i] = ANG_W'(p / 64'd4500000000);
		end
		return l;
	endfunction

	localparam lim_arr_t NL_LIM = make_lims();

	typedef enum logic [1:0] {
		ST_OK            = 2'd0,
		ST_INCOMPLETE    = 2'd1,
		ST_TOO_OLD       = 2'd2,
		ST_ZONE_MISMATCH = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		OP_LAT_EVEN,
		OP_LAT_ODD,
		OP_LON_ZONE,
		OP_LON_ANGLE
	} div_op_t;

	typedef struct packed {
		logic [ID_W-1:0]   aircraft_id;
		logic              odd_frame;
		logic [CPR_W-1:0]  cpr_lat;
		logic [CPR_W-1:0]  cpr_lon;
		logic [TIME_W-1:0] time_ms;
	} frame_t;

	typedef struct packed {
		logic                    position_valid;
		logic [1:0]              decode_status;
		logic signed [ANG_W-1:0] latitude;
		logic signed [ANG_W-1:0] longitude;
	} result_t;

	typedef struct packed {
		logic    store;
		logic    div_start;
		div_op_t div_op;
		logic    zone_even;
		logic    zone_odd;
		logic    lon_prep;
		logic    load_out;
		status_t status;
	} dp_cmd_t;

	typedef struct packed {
		logic have_pair;
		logic too_old;
		logic div_done;
		logic zone_mismatch;
	} dp_stat_t;

endpackage
`default_nettype wire

/* hw/rtl/cgpd_ifs.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cgpd channel interfaces
// Valid/ready channels for frames, results and the window register write.
// ----------------------------------------------------------------------------
interface cgpd_frame_if;
	import cgpd_pkg::*;
	logic   valid;
	logic   ready;
	frame_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface cgpd_result_if;
	import cgpd_pkg::*;
	logic    valid;
	logic    ready;
	result_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface cgpd_cfg_if;
	import cgpd_pkg::*;
	logic             valid;
	logic             ready;
	logic [WIN_W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/cgpd_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cgpd_div
// Restoring unsigned divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module cgpd_div (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [cgpd_pkg::NUM_W-1:0] num,
	input  wire logic [cgpd_pkg::DEN_W-1:0] den,
	output logic                          done,
	output logic [cgpd_pkg::NUM_W-1:0]    quo,
	output logic [cgpd_pkg::REM_W-1:0]    rem
);
	import cgpd_pkg::*;

	localparam int unsigned CNT_W = $clog2(DIV_STEPS + 1);

	logic [NUM_W-1:0] num_q;
	logic [NUM_W-1:0] quo_q;
	logic [REM_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [REM_W:0]   t1, t2, s1, s2;
	logic             q1, q2;

	// Two compare-subtract steps on the partial remainder
	always_comb begin
		t1 = {rem_q, num_q[NUM_W-1]};
		q1 = t1 >= (REM_W+1)'(den_q);
		s1 = q1 ? t1 - (REM_W+1)'(den_q) : t1;
		t2 = {s1[REM_W-1:0], num_q[NUM_W-2]};
		q2 = t2 >= (REM_W+1)'(den_q);
		s2 = q2 ? t2 - (REM_W+1)'(den_q) : t2;
	end

	// Load on start, advance one digit pair per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			quo_q <= '0;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-3:0], 2'b00};
			quo_q <= {quo_q[NUM_W-3:0], q1, q2};
			rem_q <= s2[REM_W-1:0];
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;
endmodule
`default_nettype wire

/* hw/rtl/cgpd_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cgpd_datapath
// Pair storage, window check, latitude and longitude arithmetic, result register.
// ----------------------------------------------------------------------------
module cgpd_datapath (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cgpd_pkg::frame_t   frame_data,
	input  wire cgpd_pkg::dp_cmd_t  cmd,
	output cgpd_pkg::dp_stat_t      stat,
	output cgpd_pkg::result_t       out_data,
	cgpd_cfg_if.sink                cfg
);
	import cgpd_pkg::*;

	logic [WIN_W-1:0]  window_q;
	logic [ID_W-1:0]   cur_id_q;
	logic              have_even_q, have_odd_q;
	logic [CPR_W-1:0]  even_lat_q, even_lon_q, odd_lat_q, odd_lon_q;
	logic [TIME_W-1:0] even_time_q, odd_time_q;

	logic signed [LAT_W-1:0] rlat_e_q, rlat_o_q;
	logic [ZONE_W-1:0]       nl_e_q, nl_o_q;
	logic signed [7:0]       m_q;
	logic [ZONE_W-1:0]       ni_q;
	logic [ZONE_W-1:0]       lon_zone_q;
	logic [ANG_W-1:0]        rlon_q;
	div_op_t                 op_q;
	result_t                 out_q;

	// Window register
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
		end else if (cfg.valid) begin
			window_q <= cfg.data;
		end
	end

	// Store the frame; a new aircraft drops the other half of the pair
	logic new_ac;
	assign new_ac = frame_data.aircraft_id != cur_id_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_id_q    <= '0;
			have_even_q <= 1'b0;
			have_odd_q  <= 1'b0;
		end else if (cmd.store) begin
			cur_id_q <= frame_data.aircraft_id;
			if (frame_data.odd_frame) begin
				have_odd_q  <= 1'b1;
				have_even_q <= have_even_q & ~new_ac;
			end else begin
				have_even_q <= 1'b1;
				have_odd_q  <= have_odd_q & ~new_ac;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store) begin
			if (frame_data.odd_frame) begin
				odd_lat_q  <= frame_data.cpr_lat;
				odd_lon_q  <= frame_data.cpr_lon;
				odd_time_q <= frame_data.time_ms;
			end else begin
				even_lat_q  <= frame_data.cpr_lat;
				even_lon_q  <= frame_data.cpr_lon;
				even_time_q <= frame_data.time_ms;
			end
		end
	end

	// Time gap and newer frame
	logic              even_later;
	logic              odd_newer;
	logic [TIME_W-1:0] dt;
	assign even_later = even_time_q > odd_time_q;
	assign odd_newer  = ~even_later;
	assign dt = even_later ? even_time_q - odd_time_q : odd_time_q - even_time_q;

	// Latitude zone index j and its residues mod 60 and mod 59
	logic [23:0]        e59, o60;
	logic signed [25:0] lat_sum;
	logic signed [8:0]  j;
	logic signed [8:0]  j60, j59;
	always_comb begin
		e59     = 24'(even_lat_q) * 24'd59;
		o60     = 24'(odd_lat_q) * 24'd60;
		lat_sum = $signed({2'b00, e59}) - $signed({2'b00, o60}) + 26'sd65536;
		j       = $signed(lat_sum[25:17]);
		j60     = (j < 0) ? j + 9'sd60 : j;
		j59     = j;
		if (j59 < 0) j59 = j59 + 9'sd59;
		if (j59 < 0) j59 = j59 + 9'sd59;
		if (j59 >= 9'sd59) j59 = j59 - 9'sd59;
	end

	// Longitude zone count and index m
	logic [ZONE_W-1:0]  nl_sel, nl_m1, ni_raw, ni;
	logic [22:0]        lon_pe, lon_po;
	logic signed [25:0] lon_sum;
	logic [CPR_W-1:0]   lon_sel;
	always_comb begin
		nl_sel  = odd_newer ? nl_o_q : nl_e_q;
		nl_m1   = nl_sel - 1'b1;
		ni_raw  = nl_sel - ZONE_W'(odd_newer);
		ni      = (ni_raw == '0) ? ZONE_W'(1) : ni_raw;
		lon_pe  = 23'(even_lon_q) * 23'(nl_m1);
		lon_po  = 23'(odd_lon_q) * 23'(nl_sel);
		lon_sum = $signed({3'b000, lon_pe}) - $signed({3'b000, lon_po}) + 26'sd65536;
		lon_sel = odd_newer ? odd_lon_q : even_lon_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.lon_prep) begin
			m_q  <= $signed(lon_sum[24:17]);
			ni_q <= ni;
		end
	end

	// Divider operands
	logic [NUM_W-1:0] div_num;
	logic [DEN_W-1:0] div_den;
	logic [14:0]      m_pos;
	always_comb begin
		m_pos = 15'({ni_q, 6'b000000}) + {{7{m_q[7]}}, m_q};
		case (cmd.div_op)
			OP_LAT_EVEN: begin
				div_num = {1'b0, j60[5:0], even_lat_q, 16'h0000} + NUM_W'(ZONES_EVEN);
				div_den = {ZONES_EVEN, 1'b0};
			end
			OP_LAT_ODD: begin
				div_num = {1'b0, j59[5:0], odd_lat_q, 16'h0000} + NUM_W'(ZONES_ODD);
				div_den = {ZONES_ODD, 1'b0};
			end
			OP_LON_ZONE: begin
				div_num = NUM_W'(m_pos);
				div_den = {1'b0, ni_q};
			end
			OP_LON_ANGLE: begin
				div_num = {1'b0, lon_zone_q, lon_sel, 16'h0000} + NUM_W'(ni_q);
				div_den = {ni_q, 1'b0};
			end
			default: begin
				div_num = '0;
				div_den = '0;
			end
		endcase
	end

	logic             div_done;
	logic [NUM_W-1:0] div_quo;
	logic [REM_W-1:0] div_rem;

	cgpd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	// Latitude wrap: 270 degrees and above fold to negative
	logic signed [LAT_W-1:0] lat_wrapped;
	always_comb begin
		lat_wrapped = $signed({1'b0, div_quo[LAT_W-2:0]});
		if (div_quo[LAT_W-2:0] >= 33'h0C000_0000) begin
			lat_wrapped = lat_wrapped - 34'sh1_0000_0000;
		end
	end

	// Capture the quotient or remainder of the finished operation
	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			op_q <= cmd.div_op;
		end
		if (div_done) begin
			case (op_q)
				OP_LAT_EVEN:  rlat_e_q   <= lat_wrapped;
				OP_LAT_ODD:   rlat_o_q   <= lat_wrapped;
				OP_LON_ZONE:  lon_zone_q <= div_rem[ZONE_W-1:0];
				OP_LON_ANGLE: rlon_q     <= div_quo[ANG_W-1:0];
				default:      rlon_q     <= rlon_q;
			endcase
		end
	end

	// Zone count NL from the thermometer of threshold compares
	logic signed [LAT_W-1:0] zone_in, zone_abs;
	logic [ZONE_W-1:0]       zone_cnt;
	always_comb begin
		zone_in  = cmd.zone_odd ? rlat_o_q : rlat_e_q;
		zone_abs = (zone_in < 0) ? -zone_in : zone_in;
		zone_cnt = '0;
		for (int i = 0; i < NL_THR_N; i++) begin
			zone_cnt = zone_cnt + ZONE_W'(zone_abs[ANG_W-1:0] >= NL_LIM[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.zone_even) nl_e_q <= NL_MAX - zone_cnt;
		if (cmd.zone_odd)  nl_o_q <= NL_MAX - zone_cnt;
	end

	// Result register
	logic              ok;
	logic [LAT_W-1:0]  rlat_sel;
	assign ok       = cmd.status == ST_OK;
	assign rlat_sel = odd_newer ? rlat_o_q : rlat_e_q;

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q.position_valid <= ok;
			out_q.decode_status  <= cmd.status;
			out_q.latitude       <= ok ? $signed(rlat_sel[ANG_W-1:0]) : '0;
			out_q.longitude      <= ok ? $signed(rlon_q) : '0;
		end
	end

	assign out_data = out_q;

	assign stat.have_pair     = have_even_q & have_odd_q;
	assign stat.too_old       = dt > TIME_W'(window_q);
	assign stat.div_done      = div_done;
	assign stat.zone_mismatch = nl_e_q != nl_o_q;
endmodule
`default_nettype wire

/* hw/rtl/cgpd_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cgpd_ctrl
// Sequencer for one decode: check, latitude divides, zone compare, longitude.
// ----------------------------------------------------------------------------
module cgpd_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               frame_valid,
	output logic                    frame_ready,
	output logic                    out_valid,
	input  wire logic               out_ready,
	input  wire cgpd_pkg::dp_stat_t stat,
	output cgpd_pkg::dp_cmd_t       cmd
);
	import cgpd_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_LAT_E,
		S_LAT_O,
		S_ZONE_E,
		S_ZONE_O,
		S_ZCHK,
		S_LON_START,
		S_LON_ZONE,
		S_ANG_START,
		S_LON_ANG,
		S_EMIT
	} state_t;

	state_t  state_q, state_d;
	status_t status_q, status_d;
	logic    out_valid_q;

	// Commands and next state
	always_comb begin
		state_d     = state_q;
		status_d    = status_q;
		cmd         = '0;
		cmd.status  = status_q;
		frame_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				frame_ready = 1'b1;
				if (frame_valid) begin
					cmd.store = 1'b1;
					state_d   = S_CHECK;
				end
			end
			S_CHECK: begin
				if (!stat.have_pair) begin
					status_d = ST_INCOMPLETE;
					state_d  = S_EMIT;
				end else if (stat.too_old) begin
					status_d = ST_TOO_OLD;
					state_d  = S_EMIT;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_op    = OP_LAT_EVEN;
					state_d       = S_LAT_E;
				end
			end
			S_LAT_E: begin
				if (stat.div_done) begin
					cmd.div_start = 1'b1;
					cmd.div_op    = OP_LAT_ODD;
					state_d       = S_LAT_O;
				end
			end
			S_LAT_O: begin
				if (stat.div_done) state_d = S_ZONE_E;
			end
			S_ZONE_E: begin
				cmd.zone_even = 1'b1;
				state_d       = S_ZONE_O;
			end
			S_ZONE_O: begin
				cmd.zone_odd = 1'b1;
				state_d      = S_ZCHK;
			end
			S_ZCHK: begin
				if (stat.zone_mismatch) begin
					status_d = ST_ZONE_MISMATCH;
					state_d  = S_EMIT;
				end else begin
					cmd.lon_prep = 1'b1;
					state_d      = S_LON_START;
				end
			end
			S_LON_START: begin
				cmd.div_start = 1'b1;
				cmd.div_op    = OP_LON_ZONE;
				state_d       = S_LON_ZONE;
			end
			S_LON_ZONE: begin
				if (stat.div_done) state_d = S_ANG_START;
			end
			S_ANG_START: begin
				cmd.div_start = 1'b1;
				cmd.div_op    = OP_LON_ANGLE;
				state_d       = S_LON_ANG;
			end
			S_LON_ANG: begin
				if (stat.div_done) begin
					status_d = ST_OK;
					state_d  = S_EMIT;
				end
			end
			S_EMIT: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Hold state, status and the result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			status_q    <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			status_q <= status_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
endmodule
`default_nettype wire

/* hw/rtl/cpr_global_pair_decoder.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cpr_global_pair_decoder
// Global airborne CPR position decode from an even/odd frame pair.
// ----------------------------------------------------------------------------
// Each frame request is stored as the even or odd half of the pair for the
// tracked aircraft (a new aircraft id drops the stored pair) and produces one
// result request. The decode runs through a single shared divider that yields
// two quotient bits per cycle. An incomplete or stale pair goes straight to the
// output; a full decode uses four divisions, and a new frame is accepted only
// once the previous decode has loaded its result. The next frame is taken while
// a result still waits on the output register. Angles are signed binary angles,
// 2^32 = 360 degrees.
module cpr_global_pair_decoder (
	input  wire logic     clk,
	input  wire logic     arst_n,
	cgpd_frame_if.sink    frame,
	cgpd_result_if.source result,
	cgpd_cfg_if.sink      cfg
);
	import cgpd_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	cgpd_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_valid (frame.valid),
		.frame_ready (frame.ready),
		.out_valid   (result.valid),
		.out_ready   (result.ready),
		.stat        (stat),
		.cmd         (cmd)
	);

	cgpd_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.frame_data (frame.data),
		.cmd        (cmd),
		.stat       (stat),
		.out_data   (result.data),
		.cfg        (cfg)
	);
endmodule
`default_nettype wire

/* tb/cgpd_tb_ifs.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cgpd testbench scoreboard
// Expected-result store for the CPR pair decoder: notes each accepted frame,
// predicts its decode and checks results in order.
// ----------------------------------------------------------------------------
import cgpd_pkg::*;

class cgpd_pair_scoreboard;

	logic [WIN_W-1:0]  window_ms;
	logic [ID_W-1:0]   tracked_id;
	logic [CPR_W-1:0]  ev_lat, ev_lon, od_lat, od_lon;
	logic [TIME_W-1:0] ev_time, od_time;
	bit                ev_valid, od_valid;
	result_t           pending_fixes[$];
	int                fail_count;

	function new();
		window_ms  = WINDOW_RESET;
		tracked_id = '0;
		fail_count = 0;
		drop_pair();
	endfunction

	function void drop_pair();
		ev_lat = '0; ev_lon = '0; ev_time = '0; ev_valid = 0;
		od_lat = '0; od_lon = '0; od_time = '0; od_valid = 0;
	endfunction

	// floor((v + 2^16) / 2^17)
	function longint cpr_round(longint v);
		return (v + 65536) >>> 17;
	endfunction

	function longint wrap_mod(longint a, longint b);
		longint r;
		r = a % b;
		if (r < 0) r += b;
		return r;
	endfunction

	function longint zone_angle(longint zone, longint frac, longint div);
		longint x;
		x = (zone << 17) + frac;
		return ((x << 16) + div) / (2 * div);
	endfunction

	// latitude with wrap at 270 degrees
	function longint lat_of(longint j, longint frac, longint zones);
		longint a;
		a = zone_angle(wrap_mod(j, zones), frac, zones);
		if (a >= (longint'(3) << 30)) a -= (longint'(1) << 32);
		return a;
	endfunction

	function int lon_zones(longint lat);
		logic [63:0] mag, lhs;
		int          nl;
		mag = (lat < 0) ? -lat : lat;
		lhs = mag * 64'd4500000000;
		nl = 59;
		for (int i = 0; i < NL_THR_N; i++)
			if (lhs >= (NL_THR[i] << 29)) nl--;
		return nl;
	endfunction

	// Store the frame and predict its decode
	function void note_frame(frame_t f);
		result_t     r;
		logic [31:0] gap;
		longint      j, m, lat_e, lat_o, lat;
		int          nl, ni;
		bit          odd_newer;
		r = '0;
		r.decode_status = ST_INCOMPLETE;
		if (f.aircraft_id != tracked_id) begin
			drop_pair();
			tracked_id = f.aircraft_id;
		end
		if (f.odd_frame) begin
			od_lat = f.cpr_lat; od_lon = f.cpr_lon; od_time = f.time_ms; od_valid = 1;
		end else begin
			ev_lat = f.cpr_lat; ev_lon = f.cpr_lon; ev_time = f.time_ms; ev_valid = 1;
		end
		if (ev_valid && od_valid) begin
			gap = (ev_time > od_time) ? ev_time - od_time : od_time - ev_time;
			if (gap > window_ms) begin
				r.decode_status = ST_TOO_OLD;
			end else begin
				j = cpr_round(59 * longint'(ev_lat) - 60 * longint'(od_lat));
				lat_e = lat_of(j, ev_lat, 60);
				lat_o = lat_of(j, od_lat, 59);
				if (lon_zones(lat_e) != lon_zones(lat_o)) begin
					r.decode_status = ST_ZONE_MISMATCH;
				end else begin
					odd_newer = !(ev_time > od_time);
					lat = odd_newer ? lat_o : lat_e;
					nl = lon_zones(lat);
					ni = nl - (odd_newer ? 1 : 0);
					if (ni < 1) ni = 1;
					m = cpr_round(longint'(ev_lon) * (nl - 1) - longint'(od_lon) * nl);
					r.position_valid = 1;
					r.decode_status = ST_OK;
					r.latitude = lat[31:0];
					r.longitude = 32'(zone_angle(wrap_mod(m, ni),
						odd_newer ? od_lon : ev_lon, ni));
				end
			end
		end
		pending_fixes.push_back(r);
	endfunction

	task report(string what, longint got, longint want);
		$display("error at %0t: %s got %0h expected %0h", $realtime, what, got, want);
		fail_count++;
	endtask

	task check_fix(result_t got);
		result_t want;
		if (pending_fixes.size() == 0) begin
			report("unexpected result", 0, 0);
			return;
		end
		want = pending_fixes.pop_front();
		if (got.position_valid !== want.position_valid)
			report("position_valid", got.position_valid, want.position_valid);
		if (got.decode_status !== want.decode_status)
			report("decode_status", got.decode_status, want.decode_status);
		if (got.latitude !== want.latitude)
			report("latitude", got.latitude, want.latitude);
		if (got.longitude !== want.longitude)
			report("longitude", got.longitude, want.longitude);
	endtask
endclass

/* tb/cpr_global_pair_decoder_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cpr_global_pair_decoder_tb
// Drives CPR frames and window writes with random gaps and output stalls,
// predicts every decode result and checks them in order.
// ----------------------------------------------------------------------------
module cpr_global_pair_decoder_tb;
	import cgpd_pkg::*;

	logic clk;
	logic arst_n;
	bit   quiet;

	cgpd_frame_if  frame_ch();
	cgpd_result_if result_ch();
	cgpd_cfg_if    cfg_ch();

	cgpd_pair_scoreboard fixes;

	cpr_global_pair_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.frame  (frame_ch.sink),
		.result (result_ch.source),
		.cfg    (cfg_ch.sink)
	);

	// Clock, 8 ns period
	always begin
		clk = 1'b1; #4;
		clk = 1'b0; #4;
	end

	// Watchdog
	initial begin
		#40ms;
		$display("cpr_global_pair_decoder: mismatch");
		$finish;
	end

	// Random idle burst unless in the quiet tail; drop valid while idling
	task automatic idle_burst();
		if (!quiet && $urandom_range(3) == 0) begin
			frame_ch.valid <= 1'b0;
			repeat ($urandom_range(13, 1)) @(negedge clk);
		end
	endtask

	// Present a frame and hold it until accepted; return at the next falling edge
	task automatic send_frame(frame_t f);
		idle_burst();
		frame_ch.valid <= 1'b1;
		frame_ch.data  <= f;
		do @(posedge clk); while (!frame_ch.ready);
		fixes.note_frame(f);
		@(negedge clk);
	endtask

	task automatic send_random(logic [23:0] id, bit odd, logic [31:0] t);
		frame_t f;
		f.aircraft_id = id;
		f.odd_frame   = odd;
		f.cpr_lat     = 17'($urandom);
		f.cpr_lon     = 17'($urandom);
		f.time_ms     = t;
		send_frame(f);
	endtask

	// Write the window once every result is in and the decoder has settled
	task automatic write_window(logic [15:0] w);
		frame_ch.valid <= 1'b0;
		while (fixes.pending_fixes.size() != 0) @(negedge clk);
		repeat (120) @(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= w;
		do @(posedge clk); while (!cfg_ch.ready);
		fixes.window_ms = w;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic send_pair_run(int n);
		logic [23:0] id;
		logic [31:0] t;
		id = 24'($urandom);
		t  = $urandom;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(9))
				0: id = 24'($urandom);
				1: t = $urandom;
				default: t = t + $urandom_range(fixes.window_ms + 40);
			endcase
			send_random(id, 1'($urandom_range(1)), t);
		end
	endtask

	// Output side: random stall bursts, check every accepted result
	initial begin
		int unsigned stall_n;
		stall_n = 0;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (quiet)
				stall_n = 0;
			else if (stall_n == 0 && $urandom_range(7) == 0)
				stall_n = $urandom_range(13, 1);
			if (stall_n != 0) begin
				result_ch.ready <= 1'b0;
				stall_n--;
			end else begin
				result_ch.ready <= 1'b1;
			end
			@(posedge clk);
			if (result_ch.valid && result_ch.ready)
				fixes.check_fix(result_ch.data);
		end
	end

	// Stimulus
	initial begin
		frame_t f;
		fixes = new();
		frame_ch.valid = 1'b0;
		frame_ch.data  = '0;
		cfg_ch.valid   = 1'b0;
		cfg_ch.data    = '0;
		arst_n = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: extremes, equal times, stale pair, id change
		f = '{24'h000000, 1'b0, 17'h00000, 17'h00000, 32'd0};        send_frame(f);
		f = '{24'h000000, 1'b1, 17'h1FFFF, 17'h1FFFF, 32'd0};        send_frame(f);
		f = '{24'h000000, 1'b0, 17'h1FFFF, 17'h1FFFF, 32'd10000};    send_frame(f);
		f = '{24'h000000, 1'b1, 17'h00000, 17'h00000, 32'd20001};    send_frame(f);
		f = '{24'hFFFFFF, 1'b1, 17'h15555, 17'h0AAAA, 32'hFFFFFFFF}; send_frame(f);
		f = '{24'hFFFFFF, 1'b0, 17'h0AAAA, 17'h15555, 32'hFFFFFFF0}; send_frame(f);
		f = '{24'hFFFFFF, 1'b0, 17'h10000, 17'h10000, 32'd0};        send_frame(f);
		f = '{24'h123456, 1'b0, 17'h1F000, 17'h1F000, 32'd500};      send_frame(f);
		f = '{24'h123456, 1'b1, 17'h1F800, 17'h1F800, 32'd500};      send_frame(f);
		f = '{24'h123456, 1'b0, 17'h00800, 17'h1F800, 32'd900};      send_frame(f);
		f = '{24'h123456, 1'b1, 17'h0F000, 17'h00100, 32'd400};      send_frame(f);
		f = '{24'h123456, 1'b0, 17'h0F200, 17'h00100, 32'd700};      send_frame(f);

		// Random pair runs across window settings, extremes included
		write_window(16'd0);
		send_random(24'h5A5A5A, 1'b0, 32'd77);
		send_random(24'h5A5A5A, 1'b1, 32'd77);
		send_pair_run(60);
		write_window(16'hFFFF);
		send_pair_run(300);
		write_window(16'd1000);
		send_pair_run(300);
		write_window(16'd10000);
		send_pair_run(250);
		quiet = 1'b1;
		send_pair_run(120);
		frame_ch.valid <= 1'b0;

		while (fixes.pending_fixes.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		if (fixes.fail_count == 0)
			$display("cpr_global_pair_decoder: match");
		else
			$display("cpr_global_pair_decoder: mismatch");
		$finish;
	end
endmodule
